FILE: rtl/cce_pkg.sv
package cce_pkg;

    localparam int unsigned LOW_W    = 32;
    localparam int unsigned COUNT_W  = 64;
    localparam int unsigned STEPS    = COUNT_W;
    localparam int unsigned STEP_W   = $clog2(STEPS);

    localparam logic [LOW_W-1:0] HALF_RANGE      = 32'h8000_0000;
    localparam logic [LOW_W-1:0] DIVISOR_RESET   = 32'd16000;
    localparam logic             ENABLE_RESET    = 1'b1;
    localparam logic [STEP_W-1:0] LAST_STEP      = STEP_W'(STEPS - 1);

    // register index, taken from paddr[2]
    localparam logic REG_ENABLE  = 1'b0;
    localparam logic REG_DIVISOR = 1'b1;

    localparam logic MODE_NOW     = 1'b0;
    localparam logic MODE_CAPTURE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic load;     // take an input beat, update the count, seed the divider
        logic step;     // one restoring division step
        logic publish;  // copy the finished result into the output register
    } t_cmd;

    typedef struct packed {
        logic last_step;
    } t_status;

endpackage

FILE: rtl/cce_ctrl.sv
module cce_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  cce_pkg::t_status i_status,
    output cce_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    import cce_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.last_step) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_HOLD: begin
                o_cmd.publish = slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/cce_dp.sv
module cce_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cce_pkg::t_cmd                i_cmd,
    input  logic                         i_enabled,
    input  logic [cce_pkg::LOW_W-1:0]    i_divisor,
    input  logic                         i_mode,
    input  logic [cce_pkg::LOW_W-1:0]    i_counter_low,
    input  logic [cce_pkg::LOW_W-1:0]    i_capture_low,
    output cce_pkg::t_status             o_status,
    output logic [cce_pkg::COUNT_W-1:0]  o_cycles,
    output logic [cce_pkg::LOW_W-1:0]    o_quarter_ms
);
    import cce_pkg::*;

    logic [LOW_W-1:0]   r_last_low;
    logic [LOW_W-1:0]   r_upper;
    logic [LOW_W-1:0]   r_div;
    logic [LOW_W-1:0]   r_rem;
    logic [COUNT_W-1:0] r_quo;
    logic [COUNT_W-1:0] r_result;
    logic [STEP_W-1:0]  r_step;
    logic [COUNT_W-1:0] r_o_cycles;
    logic [LOW_W-1:0]   r_o_qms;

    logic [LOW_W-1:0]   upper_now;
    logic [LOW_W-1:0]   now_upper;
    logic [LOW_W-1:0]   now_low;
    logic [LOW_W-1:0]   cap_ahead;
    logic               step_back;
    logic [COUNT_W-1:0] result;
    logic [LOW_W:0]     shifted;
    logic [LOW_W:0]     diff;
    logic               fits;

    // current count: bump the upper word when the sample wrapped
    assign upper_now = (i_counter_low < r_last_low) ? r_upper + LOW_W'(1) : r_upper;
    assign now_upper = i_enabled ? upper_now : '0;
    assign now_low   = i_enabled ? i_counter_low : '0;

    // a capture more than half a range ahead belongs to the previous epoch
    assign cap_ahead = i_capture_low - now_low;
    assign step_back = (i_capture_low > now_low) && (cap_ahead > HALF_RANGE);

    always_comb begin
        case (i_mode)
            MODE_CAPTURE: begin
                result = {(step_back ? now_upper - LOW_W'(1) : now_upper), i_capture_low};
            end
            default: result = {now_upper, now_low};
        endcase
    end

    // restoring divider, one quotient bit a step; a zero divisor yields all ones
    assign shifted = {r_rem, r_quo[COUNT_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_low <= '0;
            r_upper    <= '0;
        end else if (i_cmd.load && i_enabled) begin
            r_last_low <= i_counter_low;
            r_upper    <= upper_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div    <= i_divisor;
            r_rem    <= '0;
            r_quo    <= result;
            r_result <= result;
            r_step   <= '0;
        end else if (i_cmd.step) begin
            r_rem  <= fits ? diff[LOW_W-1:0] : shifted[LOW_W-1:0];
            r_quo  <= {r_quo[COUNT_W-2:0], fits};
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.publish) begin
            r_o_cycles <= r_result;
            r_o_qms    <= r_quo[LOW_W-1:0];
        end
    end

    assign o_status.last_step = (r_step == LAST_STEP);
    assign o_cycles           = r_o_cycles;
    assign o_quarter_ms       = r_o_qms;

endmodule

FILE: rtl/cycle_counter_extender_unit.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+------------------------------------
// input    | in        | i_in_valid / o_in_ready    | i_mode, i_counter_low, i_capture_low
// output   | out       | o_out_valid / i_out_ready  | o_cycles, o_quarter_ms
// config   | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// A beat is taken in the load cycle, then 64 restoring divider steps (one
// quotient bit each) and a publish step follow: the publish step writes the
// result register, and the next beat is taken only after it. Synchronous
// active-low reset clears the count, the handshake state and the registers
// to their reset values. A result waiting on the output does not stop the
// next beat from entering; only the publish step waits for the slot, and the
// input stays closed until it goes.
module cycle_counter_extender_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [cce_pkg::LOW_W-1:0]   i_counter_low,
    input  logic [cce_pkg::LOW_W-1:0]   i_capture_low,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [cce_pkg::COUNT_W-1:0] o_cycles,
    output logic [cce_pkg::LOW_W-1:0]   o_quarter_ms,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cce_pkg::*;

    logic             r_enabled;
    logic [LOW_W-1:0] r_divisor;
    logic             cfg_write;
    t_cmd             cmd;
    t_status          status;

    // register writes land on the access phase; pready never stalls
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= ENABLE_RESET;
            r_divisor <= DIVISOR_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_ENABLE:  r_enabled <= pwdata[0];
                REG_DIVISOR: r_divisor <= pwdata;
                default: ;
            endcase
        end
    end

    // read back the selected register
    always_comb begin
        unique case (paddr[2])
            REG_ENABLE:  prdata = {31'b0, r_enabled};
            REG_DIVISOR: prdata = r_divisor;
            default:     prdata = '0;
        endcase
    end

    // sequencer: idle, divide, hold until the output slot frees
    cce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    // count extension, capture extension, divider and output register
    cce_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_enabled     (r_enabled),
        .i_divisor     (r_divisor),
        .i_mode        (i_mode),
        .i_counter_low (i_counter_low),
        .i_capture_low (i_capture_low),
        .o_status      (status),
        .o_cycles      (o_cycles),
        .o_quarter_ms  (o_quarter_ms)
    );

`ifndef NO_ASSERTIONS
    // an accepted beat makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready after a beat was taken");

    // publish never overwrites a result that has not been taken
    a_publish_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten while held");

    // publish raises output valid in the next cycle
    a_publish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |=> o_out_valid)
        else $error("publish did not raise output valid");

    // load never overlaps a divide step or a publish
    a_load_not_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load && (cmd.step || cmd.publish)))
        else $error("load issued while divider busy");
`endif

endmodule
